/* src/mjq_pkg.sv */
// mjq_pkg: request and status codes and the cell control struct
// of the minimum priority job queue
// no dependencies
package mjq_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

/* src/min_priority_job_queue_top.sv */
// min_priority_job_queue_top: sorted minimum priority job queue
// built from a row of mjq_cell slots; depends on mjq_pkg and mjq_cell
// the result strobe rises in the cycle after the start transfer
// throughput: one request per cycle, every slot compares in parallel
// busy is held low; the receiver cannot stall the result
// reset clears the job count and the strobe, slot contents are left as is
module min_priority_job_queue_top #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_req_type,
  input  logic [ID_BITS-1:0]           in_job_id,
  input  logic [PRIO_BITS-1:0]         in_job_priority,
  output logic                         out_strobe,
  output logic [1:0]                   out_status,
  output logic [ID_BITS-1:0]           out_front_id,
  output logic [PRIO_BITS-1:0]         out_front_priority,
  output logic [$clog2(DEPTH+1)-1:0]   out_occupancy
);
  import mjq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r;
  logic [1:0]           status_r, status_nxt;
  logic [ID_BITS-1:0]   front_id_r, front_id_nxt;
  logic [PRIO_BITS-1:0] front_prio_r, front_prio_nxt;

  logic                 full, empty, accept;
  cell_ctrl_t           ctrl;

  logic [ID_BITS-1:0]   cell_id   [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic                 cell_le   [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign ctrl.insert = accept && (in_req_type == REQ_INSERT) && !full;
  assign ctrl.remove = accept && (in_req_type == REQ_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_le;
    logic [ID_BITS-1:0]   l_id,   r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_le   = 1'b1;
      assign l_id   = '0;
      assign l_prio = '0;
    end else begin : g_body
      assign l_le   = cell_le[i-1];
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_id   = cell_id[i];
      assign r_prio = cell_prio[i];
    end else begin : g_mid
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    mjq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (count_r > CNT_W'(i)),
      .new_id     (in_job_id),
      .new_prio   (in_job_priority),
      .left_le    (l_le),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_prio (r_prio),
      .own_le     (cell_le[i]),
      .id_r       (cell_id[i]),
      .prio_r     (cell_prio[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    status_nxt     = STAT_OK;
    front_id_nxt   = '0;
    front_prio_nxt = '0;
    case (in_req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          front_id_nxt   = cell_id[0];
          front_prio_nxt = cell_prio[0];
          if (in_req_type == REQ_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      front_id_r   <= front_id_nxt;
      front_prio_r <= front_prio_nxt;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_front_id       = front_id_r;
  assign out_front_priority = front_prio_r;
  assign out_occupancy      = count_r;

endmodule

/* src/mjq_cell.sv */
// mjq_cell: one slot of the sorted shift queue, holds an id and a priority
// depends on mjq_pkg
module mjq_cell #(
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                  clk,
  input  mjq_pkg::cell_ctrl_t   ctrl,
  input  logic                  slot_valid,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic                  left_le,
  input  logic [ID_BITS-1:0]    left_id,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic [ID_BITS-1:0]    right_id,
  input  logic [PRIO_BITS-1:0]  right_prio,
  output logic                  own_le,
  output logic [ID_BITS-1:0]    id_r,
  output logic [PRIO_BITS-1:0]  prio_r
);
  import mjq_pkg::*;

  logic [ID_BITS-1:0]   id_nxt;
  logic [PRIO_BITS-1:0] prio_nxt;

  // held job stays ahead of the new one when its priority is lower or equal
  assign own_le = slot_valid && (prio_r <= new_prio);

  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    if (ctrl.insert) begin
      if (!own_le) begin
        if (left_le) begin
          id_nxt   = new_id;
          prio_nxt = new_prio;
        end else begin
          id_nxt   = left_id;
          prio_nxt = left_prio;
        end
      end
    end else if (ctrl.remove) begin
      id_nxt   = right_id;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

/* tb/sv/tb_min_priority_job_queue_top.sv */
// tb_min_priority_job_queue_top: self-checking bench for the sorted minimum priority job queue
// directed table then biased random requests, checked against table or local queue model
// depends on mjq_pkg and min_priority_job_queue_top
module tb_min_priority_job_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mjq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int ID_BITS    = 16;
  localparam int PRIO_BITS  = 8;
  localparam int OCC_BITS   = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS = 1750;
  localparam int CALM_TAIL  = 200;
  localparam int DOG_LIMIT  = 1000;
  localparam int TABLE_ROWS = 26;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           status;
    logic [ID_BITS-1:0]   front_id;
    logic [PRIO_BITS-1:0] front_priority;
    logic [OCC_BITS-1:0]  occupancy;
  } job_result_t;

  typedef struct packed {
    logic [1:0]           req;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic                 typed;
    job_result_t          want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type = '0;
  logic [ID_BITS-1:0]   in_job_id = '0;
  logic [PRIO_BITS-1:0] in_job_priority = '0;
  logic                 out_strobe;
  logic [1:0]           out_status;
  logic [ID_BITS-1:0]   out_front_id;
  logic [PRIO_BITS-1:0] out_front_priority;
  logic [OCC_BITS-1:0]  out_occupancy;

  logic                 row_typed = 1'b0;
  job_result_t          row_want = '0;

  logic [ID_BITS-1:0]   held_id [DEPTH];
  logic [PRIO_BITS-1:0] held_prio [DEPTH];
  int                   held_jobs = 0;

  job_result_t          awaited_results [$];
  stim_row_t            directed_rows [TABLE_ROWS];
  int                   error_count = 0;
  int                   quiet_cycles = 0;

  min_priority_job_queue_top #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_job_id          (in_job_id),
    .in_job_priority    (in_job_priority),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_front_id       (out_front_id),
    .out_front_priority (out_front_priority),
    .out_occupancy      (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic job_result_t serve_request(input logic [1:0] req,
                                                input logic [ID_BITS-1:0] id,
                                                input logic [PRIO_BITS-1:0] prio);
    job_result_t r;
    int          pos;
    r = '0;
    case (req)
      REQ_INSERT: begin
        if (held_jobs >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < held_jobs && held_prio[pos] <= prio) pos++;
          for (int i = held_jobs; i > pos; i--) begin
            held_id[i]   = held_id[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_id[pos]   = id;
          held_prio[pos] = prio;
          held_jobs++;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (held_jobs == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.front_id       = held_id[0];
          r.front_priority = held_prio[0];
          if (req == REQ_REMOVE) begin
            for (int i = 0; i + 1 < held_jobs; i++) begin
              held_id[i]   = held_id[i+1];
              held_prio[i] = held_prio[i+1];
            end
            held_jobs--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = held_jobs[OCC_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result check first, then the transfer taken at this edge
  always @(posedge clk) begin
    job_result_t want;
    job_result_t predicted;
    if (rst_n) begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected none actual %0h/%0h/%0h/%0h",
                   $time, out_status, out_front_id, out_front_priority, out_occupancy);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("front_id", 32'(want.front_id), 32'(out_front_id));
          check_field("front_priority", 32'(want.front_priority), 32'(out_front_priority));
          check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
        end
      end
      if (start && !busy) begin
        predicted = serve_request(in_req_type, in_job_id, in_job_priority);
        awaited_results.insert(awaited_results.size(), row_typed ? row_want : predicted);
      end
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= DOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [ID_BITS-1:0] id,
                              input logic [PRIO_BITS-1:0] prio, input logic typed,
                              input job_result_t want);
    logic ok;
    start           <= 1'b1;
    in_req_type     <= req;
    in_job_id       <= id;
    in_job_priority <= prio;
    row_typed       <= typed;
    row_want        <= want;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic hold_off(input int cycles);
    start     <= 1'b0;
    row_typed <= 1'b0;
    for (int c = 0; c < cycles; c++) begin
      in_req_type     <= 2'($urandom);
      in_job_id       <= ID_BITS'($urandom);
      in_job_priority <= PRIO_BITS'($urandom);
      @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0]           req;
    logic [PRIO_BITS-1:0] prio;
    int                   insert_pct;
    int                   roll;
    directed_rows = '{
      '{REQ_PEEK,   16'h0000, 8'h00, 1'b1, '{STAT_EMPTY, 16'h0000, 8'h00, 5'd0}},
      '{REQ_REMOVE, 16'h0000, 8'h00, 1'b1, '{STAT_EMPTY, 16'h0000, 8'h00, 5'd0}},
      '{REQ_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd1}},
      '{REQ_INSERT, 16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd2}},
      '{REQ_INSERT, 16'h1234, 8'h00, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd3}},
      '{REQ_PEEK,   16'hAAAA, 8'h55, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd3}},
      '{REQ_REMOVE, 16'h5555, 8'hAA, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd2}},
      '{REQ_UNUSED, 16'h5A5A, 8'h5A, 1'b1, '{STAT_OK,    16'h0000, 8'h00, 5'd2}},
      '{REQ_REMOVE, 16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'h1234, 8'h00, 5'd1}},
      '{REQ_INSERT, 16'h0101, 8'h80, 1'b0, '0},
      '{REQ_INSERT, 16'h0102, 8'h40, 1'b0, '0},
      '{REQ_INSERT, 16'h0103, 8'hFF, 1'b0, '0},
      '{REQ_INSERT, 16'h0104, 8'h01, 1'b0, '0},
      '{REQ_INSERT, 16'h0105, 8'h40, 1'b0, '0},
      '{REQ_INSERT, 16'h0106, 8'hFE, 1'b0, '0},
      '{REQ_INSERT, 16'h0107, 8'h7F, 1'b0, '0},
      '{REQ_INSERT, 16'h0108, 8'h01, 1'b0, '0},
      '{REQ_INSERT, 16'h0109, 8'h20, 1'b0, '0},
      '{REQ_INSERT, 16'h010A, 8'h10, 1'b0, '0},
      '{REQ_INSERT, 16'h010B, 8'hC0, 1'b0, '0},
      '{REQ_INSERT, 16'h010C, 8'h08, 1'b0, '0},
      '{REQ_INSERT, 16'h010D, 8'h40, 1'b0, '0},
      '{REQ_INSERT, 16'h010E, 8'h02, 1'b0, '0},
      '{REQ_INSERT, 16'h010F, 8'hF0, 1'b0, '0},
      '{REQ_INSERT, 16'hBEEF, 8'h00, 1'b1, '{STAT_FULL,  16'h0000, 8'h00, 5'd16}},
      '{REQ_PEEK,   16'h0000, 8'h00, 1'b0, '0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].id, directed_rows[k].prio,
                   directed_rows[k].typed, directed_rows[k].want);
      if ($urandom_range(3) == 0) hold_off($urandom_range(1, 4));
    end

    // insert bias swings so the queue runs full and empty many times
    insert_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 125 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        req = REQ_UNUSED;
      end else if (roll < insert_pct) begin
        req = REQ_INSERT;
      end else begin
        req = ($urandom_range(3) == 0) ? REQ_PEEK : REQ_REMOVE;
      end
      prio = $urandom_range(1) ? PRIO_BITS'($urandom_range(3)) : PRIO_BITS'($urandom);
      send_request(req, ID_BITS'($urandom), prio, 1'b0, '0);
      if (n < RAND_ITEMS - CALM_TAIL && $urandom_range(3) == 0) begin
        hold_off($urandom_range(1, 4));
      end
    end
    start     <= 1'b0;
    row_typed <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mjq_pkg.sv
src/mjq_cell.sv
src/min_priority_job_queue_top.sv
tb/sv/tb_min_priority_job_queue_top.sv
